### sv/vrb_pkg.sv
`timescale 1ns / 1ps

package vrb_pkg;

  localparam int ADDR_W = 7;
  localparam int CFG_W  = 6;
  localparam int BYTE_W = 8;

  localparam logic [CFG_W-1:0] CONTROL_ADDRESS_RESET = 6'd4;

  localparam int CTRL_READY_BIT = 1;
  localparam int CTRL_IE_BIT    = 6;
  localparam int WRITE_FLAG_BIT = 7;

  typedef enum logic [1:0] {
    OP_BUS_READ    = 2'd0,
    OP_BUS_WRITE   = 2'd1,
    OP_CORE_UPDATE = 2'd2,
    OP_CONV_DONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    PREG_STATUS = 2'd0,
    PREG_WRITE  = 2'd1,
    PREG_READ   = 2'd2,
    PREG_UNUSED = 2'd3
  } bus_reg_t;

  typedef struct packed {
    logic load;
    logic fetch;
    logic apply;
    logic ctrl_fetch;
    logic result;
  } vrb_cmd_t;

endpackage

### sv/vrb_ctrl.sv
`timescale 1ns / 1ps

module vrb_ctrl
  import vrb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output vrb_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_APPLY,
    S_CTRL,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.load       = (state == S_IDLE) && in_valid;
    cmd.fetch      = (state == S_FETCH);
    cmd.apply      = (state == S_APPLY);
    cmd.ctrl_fetch = (state == S_CTRL);
    cmd.result     = (state == S_RESULT) && out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH:  state_next = S_APPLY;
      S_APPLY:  state_next = S_CTRL;
      S_CTRL:   state_next = S_RESULT;
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.result) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after accepting a word");

  a_result_sets_valid: assert property (@(posedge clk) disable iff (rst)
    state == S_RESULT && !out_valid |=> out_valid)
    else $error("result not presented");

  a_taken_clears_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && state != S_RESULT |=> !out_valid)
    else $error("result word repeated");

  a_valid_from_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_RESULT)
    else $error("result word without finished item");

endmodule

### sv/vrb_datapath.sv
`timescale 1ns / 1ps

module vrb_datapath
  import vrb_pkg::*;
#(
  parameter int STORE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  vrb_cmd_t          cmd,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic [1:0]        opcode,
  input  logic [1:0]        bus_reg,
  input  logic [BYTE_W-1:0] bus_data,
  input  logic [CFG_W-1:0]  core_address,
  input  logic [BYTE_W-1:0] core_data,
  output logic [BYTE_W-1:0] read_data,
  output logic              read_valid_flag,
  output logic              interrupt_out
);

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [ADDR_W:0] DEPTH_L = (ADDR_W + 1)'(STORE_DEPTH);

  opcode_t             op_q;
  bus_reg_t            reg_q;
  logic [BYTE_W-1:0]   bdata_q;
  logic [CFG_W-1:0]    caddr_q;
  logic [BYTE_W-1:0]   cdata_q;

  logic [CFG_W-1:0]    control_address;
  logic [BYTE_W-1:0]   read_latch;
  logic                read_valid;
  logic                write_pending;
  logic [ADDR_W-1:0]   pending_address;
  logic [BYTE_W-1:0]   rd_q;

  logic [BYTE_W-1:0]   mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] mem_valid;
  logic [BYTE_W-1:0]   mem_q;
  logic                hit_q;
  logic [BYTE_W-1:0]   rdata;

  logic [ADDR_W-1:0]   rd_addr;
  logic                rd_en;
  logic                rd_in_range;

  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [BYTE_W-1:0]   wr_data;
  logic                wr_in_range;

  assign rdata = hit_q ? mem_q : '0;

  always_comb begin
    if (cmd.ctrl_fetch || op_q == OP_CONV_DONE) begin
      rd_addr = {1'b0, control_address};
    end else begin
      rd_addr = bdata_q[ADDR_W-1:0];
    end
    rd_en       = cmd.fetch || cmd.ctrl_fetch;
    rd_in_range = {1'b0, rd_addr} < DEPTH_L;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pending_address;
    wr_data = bdata_q;
    if (cmd.apply) begin
      case (op_q)
        OP_BUS_WRITE: begin
          wr_en = (reg_q == PREG_WRITE) && write_pending;
        end
        OP_CORE_UPDATE: begin
          wr_en   = 1'b1;
          wr_addr = {1'b0, caddr_q};
          wr_data = cdata_q;
        end
        OP_CONV_DONE: begin
          wr_en   = 1'b1;
          wr_addr = {1'b0, control_address};
          wr_data = rdata | (BYTE_W'(1) << CTRL_READY_BIT);
        end
        default: wr_en = 1'b0;
      endcase
    end
    wr_in_range = {1'b0, wr_addr} < DEPTH_L;
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_in_range) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_valid <= '0;
      hit_q     <= 1'b0;
    end else begin
      if (wr_en && wr_in_range) begin
        mem_valid[wr_addr[AW-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        hit_q <= rd_in_range && mem_valid[rd_addr[AW-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= opcode_t'(opcode);
      reg_q   <= bus_reg_t'(bus_reg);
      bdata_q <= bus_data;
      caddr_q <= core_address;
      cdata_q <= core_data;
    end
    if (cmd.result) begin
      read_data       <= rd_q;
      read_valid_flag <= read_valid;
      interrupt_out   <= rdata[CTRL_IE_BIT] & rdata[CTRL_READY_BIT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_address <= CONTROL_ADDRESS_RESET;
      read_latch      <= '0;
      read_valid      <= 1'b0;
      write_pending   <= 1'b0;
      pending_address <= '0;
      rd_q            <= '0;
    end else begin
      if (cfg_we) begin
        control_address <= cfg_data;
      end
      if (cmd.apply) begin
        case (op_q)
          OP_BUS_READ: begin
            if (reg_q == PREG_STATUS) begin
              rd_q <= {{(BYTE_W-1){1'b0}}, read_valid};
            end else if (reg_q == PREG_READ) begin
              rd_q       <= read_latch;
              read_valid <= 1'b0;
            end else begin
              rd_q <= '0;
            end
          end
          OP_BUS_WRITE: begin
            rd_q <= '0;
            if (reg_q == PREG_WRITE) begin
              if (write_pending) begin
                write_pending <= 1'b0;
              end else if (bdata_q[WRITE_FLAG_BIT]) begin
                pending_address <= bdata_q[ADDR_W-1:0];
                write_pending   <= 1'b1;
              end else begin
                read_latch <= rdata;
                read_valid <= 1'b1;
              end
            end
          end
          default: rd_q <= '0;
        endcase
      end
    end
  end

endmodule

### sv/virtual_register_bridge_core.sv
`timescale 1ns / 1ps

// Once a word is accepted, the register store is read, the update is applied, the
// control register is read, and the result is registered, with both reads on the
// single read port of the store. The next word is accepted only once the block is
// idle again, not while the last word is in flight; while the output is stalled, a
// finished word waits in its last step until the previous result word is taken.
// The store clears at reset through one valid bit per entry, so no clearing pass
// is needed.

module virtual_register_bridge_core
  import vrb_pkg::*;
#(
  parameter int STORE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        opcode,
  input  logic [1:0]        bus_reg,
  input  logic [BYTE_W-1:0] bus_data,
  input  logic [CFG_W-1:0]  core_address,
  input  logic [BYTE_W-1:0] core_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] read_data,
  output logic              read_valid_flag,
  output logic              interrupt_out
);

  vrb_cmd_t cmd;

  vrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  vrb_datapath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .opcode          (opcode),
    .bus_reg         (bus_reg),
    .bus_data        (bus_data),
    .core_address    (core_address),
    .core_data       (core_data),
    .read_data       (read_data),
    .read_valid_flag (read_valid_flag),
    .interrupt_out   (interrupt_out)
  );

endmodule
